/* src/plc_pkg.sv */
// Shared types and constants for the positional list block.
package plc_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int LEN_W        = 7;
  // Wide enough for any cell index, position or count across the capacity range.
  localparam int IDX_W        = 11;
  localparam int GRP_SIZE     = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic                     kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] item_value;
    logic [LEN_W-1:0]         list_length;
  } rsp_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

/* src/plc_cell.sv */
// One list slot: holds an entry and shifts with its neighbors on insert or delete.
module plc_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  plc_pkg::cell_cmd_t                cmd,
  input  logic signed [plc_pkg::DATA_W-1:0] left_entry,
  input  logic signed [plc_pkg::DATA_W-1:0] right_entry,
  output logic signed [plc_pkg::DATA_W-1:0] entry,
  output logic signed [plc_pkg::DATA_W-1:0] tap
);
  import plc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [DATA_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      OP_INS: begin
        if (MY_IDX > cmd.idx) begin
          entry_next = left_entry;
        end else if (MY_IDX == cmd.idx) begin
          entry_next = cmd.value;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          entry_next = right_entry;
        end
      end
      default: entry_next = entry;
    endcase
  end

  // Pre-shift value of the addressed slot, zero elsewhere.
  assign tap = (MY_IDX == cmd.idx) ? entry : '0;

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* src/positional_list_insert_delete.sv */
// Top level of the positional list: control, length counter and the row of cells.
//
// Usage: a request (kind, position, value) is taken on the edge where start is
// high and busy is low. Insert places value at 1-based position 1..length+1 and
// shifts later entries up; delete removes the entry at 1..length and shifts
// later entries down. Every request gives one result on rsp, shown for exactly
// one cycle with done high: status, the inserted or removed value (0 on
// failure) and the list length after the request.
// The accepted request is worked on in state S_EXEC and its result is shown in
// state S_REPLY. In S_EXEC a successful request shifts the entries at and after
// the addressed slot, and the tap of the addressed slot is registered in groups
// that are merged into the removed entry. busy is high for one cycle after each
// accept, and the next request can be taken in the cycle that shows the result.
// Reset (rst, synchronous) empties the list; stored entries are not cleared
// and are never read before they are written. Results cannot be held off.
module positional_list_insert_delete #(
  parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  plc_pkg::req_t req,
  output logic          done,
  output plc_pkg::rsp_t rsp
);
  import plc_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  state_t state, state_next;
  req_t   req_q;
  logic [CNT_W-1:0] count, count_next;
  status_t status_q, status_next;
  logic signed [DATA_W-1:0] val_q, val_next;
  logic use_tap, use_tap_next;

  cell_cmd_t cmd;
  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic signed [DATA_W-1:0] tap   [CAPACITY];
  logic signed [DATA_W-1:0] grp      [NGRP];
  logic signed [DATA_W-1:0] grp_next [NGRP];
  logic signed [DATA_W-1:0] removed;

  logic [IDX_W-1:0] pos_w, cnt_w;
  logic pos_zero, ins_range, del_range, full;

  // Next state
  always_comb begin
    case (state)
      S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_REPLY;
      S_REPLY: state_next = start ? S_EXEC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    busy = 1'b0;
    done = 1'b0;
    case (state)
      S_EXEC:  busy = 1'b1;
      S_REPLY: done = 1'b1;
      default: begin
        busy = 1'b0;
        done = 1'b0;
      end
    endcase
  end

  // Request check and cell command
  always_comb begin
    pos_w     = IDX_W'(req_q.position);
    cnt_w     = IDX_W'(count);
    pos_zero  = (req_q.position == '0);
    ins_range = !pos_zero && (pos_w <= cnt_w + IDX_W'(1));
    del_range = !pos_zero && (pos_w <= cnt_w);
    full      = (cnt_w >= IDX_W'(CAPACITY));

    cmd.op    = OP_HOLD;
    cmd.idx   = pos_w - IDX_W'(1);
    cmd.value = req_q.value;

    count_next   = count;
    status_next  = ST_BAD_POS;
    val_next     = '0;
    use_tap_next = 1'b0;

    if (req_q.kind == KIND_INSERT) begin
      if (!ins_range) begin
        status_next = ST_BAD_POS;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
        val_next    = req_q.value;
        count_next  = count + CNT_W'(1);
        if (state == S_EXEC) begin
          cmd.op = OP_INS;
        end
      end
    end else begin
      if (del_range) begin
        status_next  = ST_OK;
        use_tap_next = 1'b1;
        count_next   = count - CNT_W'(1);
        if (state == S_EXEC) begin
          cmd.op = OP_DEL;
        end
      end
    end
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in, right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = entry[i+1];
    end
    plc_cell #(.INDEX(i)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .left_entry  (left_in),
      .right_entry (right_in),
      .entry       (entry[i]),
      .tap         (tap[i])
    );
  end

  // First level of the tap merge: groups of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | tap[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_comb begin
    removed = '0;
    for (int g = 0; g < NGRP; g++) begin
      removed = removed | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (state == S_EXEC) begin
      status_q <= status_next;
      val_q    <= val_next;
      use_tap  <= use_tap_next;
      for (int g = 0; g < NGRP; g++) begin
        grp[g] <= grp_next[g];
      end
    end
  end

  assign rsp.status      = status_q;
  assign rsp.item_value  = use_tap ? removed : val_q;
  assign rsp.list_length = LEN_W'(count);

endmodule

/* src/plc_chk.sv */
// Port-level checks for the positional list, bound to the top level.
module plc_chk #(
  parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input plc_pkg::rsp_t rsp
);
  import plc_pkg::*;

  // Every accepted request is worked on in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request not taken into work");

  // Work always ends in exactly one result beat.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("work cycle not followed by a result beat");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.item_value == '0)
    else $error("failed request returned a nonzero value");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_FULL |-> rsp.list_length == LEN_W'(CAPACITY))
    else $error("store full reported below capacity");

  // Length shown during the work cycle stays put on a failed request.
  a_len_hold: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.list_length == $past(rsp.list_length))
    else $error("length changed on a failed request");

endmodule

bind positional_list_insert_delete plc_chk #(.CAPACITY(CAPACITY)) u_plc_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the positional list insert/delete block.
`timescale 1ns / 100ps

module tb;
  import plc_pkg::*;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  logic  clk   = 1'b0;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  req_t  req   = '0;
  logic  busy;
  logic  done;
  rsp_t  rsp;

  // Golden copy of the list contents, index 0 is position 1.
  logic signed [DATA_W-1:0] list_model[$];
  rsp_t                     expected_rsps[$];

  int error_count  = 0;
  int cycle_count  = 0;
  int n_insert_ok  = 0;
  int n_delete_ok  = 0;
  int n_bad_pos    = 0;
  int n_full       = 0;
  int peak_length  = 0;
  rsp_t want;

  positional_list_insert_delete #(
    .CAPACITY(LIST_CAP)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("positional_list_insert_delete verification failed");
      $finish;
    end
  end

  // Applies one request to the golden list and returns the result it must give.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    int   len;
    int   p;
    len = list_model.size();
    p   = r.position;
    o.status     = ST_OK;
    o.item_value = '0;
    if (r.kind == KIND_INSERT) begin
      if (p < 1 || p > len + 1) begin
        o.status = ST_BAD_POS;
        n_bad_pos++;
      end else if (len >= LIST_CAP) begin
        o.status = ST_FULL;
        n_full++;
      end else begin
        list_model.insert(p - 1, r.value);
        o.item_value = r.value;
        n_insert_ok++;
      end
    end else begin
      if (p < 1 || p > len) begin
        o.status = ST_BAD_POS;
        n_bad_pos++;
      end else begin
        o.item_value = list_model[p - 1];
        list_model.delete(p - 1);
        n_delete_ok++;
      end
    end
    o.list_length = LEN_W'(list_model.size());
    if (list_model.size() > peak_length) peak_length = list_model.size();
    return o;
  endfunction

  // Result beats cannot be stalled; every done pulse is checked here.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("result beat with no request outstanding");
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          error_count++;
        end
        if (rsp.item_value !== want.item_value) begin
          $error("item_value: expected %0d, got %0d", want.item_value, rsp.item_value);
          error_count++;
        end
        if (rsp.list_length !== want.list_length) begin
          $error("list_length: expected %0d, got %0d", want.list_length, rsp.list_length);
          error_count++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one request beat, waits for the accept edge, idles if gap is nonzero.
  task automatic send_req(input logic kind, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] value, input int gap);
    req_t r;
    r = '{kind: kind, position: pos, value: value};
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_rsps.push_back(apply_request(r));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_req(KIND_DELETE, 8'd1,   32'sd0, 0);            // delete on empty list
    send_req(KIND_DELETE, 8'd0,   32'sd0, 0);
    send_req(KIND_INSERT, 8'd0,   32'sd5, 0);            // position zero
    send_req(KIND_INSERT, 8'd2,   32'sd6, 0);            // past end on empty
    send_req(KIND_INSERT, 8'd1,   32'h7FFF_FFFF, 0);
    send_req(KIND_INSERT, 8'd2,   32'h8000_0000, 0);     // append
    send_req(KIND_INSERT, 8'd1,   -32'sd1, 0);           // front
    send_req(KIND_INSERT, 8'd2,   32'sd0, 0);            // middle
    send_req(KIND_INSERT, 8'd5,   32'hA5A5_A5A5, 0);     // at length+1
    send_req(KIND_INSERT, 8'd7,   32'sd9, 0);            // past end
    send_req(KIND_INSERT, 8'd255, 32'sd10, 0);
    send_req(KIND_DELETE, 8'd6,   32'sd0, 0);            // past end
    send_req(KIND_DELETE, 8'd255, 32'sd0, 0);
    send_req(KIND_DELETE, 8'd3,   32'sd0, 1);            // middle
    send_req(KIND_DELETE, 8'd4,   32'sd0, 2);            // last entry
    send_req(KIND_DELETE, 8'd1,   32'h5A5A_5A5A, 0);     // front, value ignored
    send_req(KIND_DELETE, 8'd2,   -32'sd1, 0);
    send_req(KIND_DELETE, 8'd1,   32'sd0, 0);
    send_req(KIND_DELETE, 8'd1,   32'sd0, 0);            // delete on empty list again
    wait_drained();
  endtask

  task automatic test_full_store();
    while (list_model.size() < LIST_CAP)
      send_req(KIND_INSERT, POS_W'($urandom_range(1, list_model.size() + 1)), $urandom,
               pick_gap());
    send_req(KIND_INSERT, 8'd1,  32'sd11, 0);            // full
    send_req(KIND_INSERT, 8'd65, 32'sd12, 0);            // full at length+1
    send_req(KIND_INSERT, 8'd66, 32'sd13, 0);            // position check wins
    send_req(KIND_INSERT, 8'd0,  32'sd14, 0);
    send_req(KIND_DELETE, 8'd65, 32'sd0, 0);
    send_req(KIND_DELETE, 8'd64, 32'sd0, 0);
    send_req(KIND_INSERT, 8'd64, 32'sd15, 0);
    send_req(KIND_INSERT, 8'd32, 32'sd16, 0);
    while (list_model.size() > 0)
      send_req(KIND_DELETE, POS_W'($urandom_range(1, list_model.size())), $urandom,
               pick_gap());
    send_req(KIND_DELETE, 8'd1, 32'sd0, 0);
    wait_drained();
  endtask

  // Mostly legal positions with a random mix of kinds; ins_pct steers the length.
  task automatic test_random_mix(input int n, input int ins_pct);
    int         len;
    int         r;
    logic       kind;
    logic [7:0] pos;
    for (int i = 0; i < n; i++) begin
      len  = list_model.size();
      kind = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_DELETE;
      r    = $urandom_range(0, 99);
      if (r < 88) begin
        if (kind == KIND_INSERT) pos = POS_W'($urandom_range(1, len + 1));
        else if (len == 0)       pos = 8'd1;
        else                     pos = POS_W'($urandom_range(1, len));
      end else if (r < 94) begin
        pos = 8'd0;
      end else begin
        pos = POS_W'($urandom_range(0, 255));
      end
      send_req(kind, pos, $urandom, pick_gap());
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random_mix(60, 70);
    test_random_mix(60, 85);
    test_random_mix(60, 20);
    test_random_mix(60, 55);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("inserts ok %0d, deletes ok %0d, bad position %0d, full store %0d",
             n_insert_ok, n_delete_ok, n_bad_pos, n_full);
    $display("peak list length %0d of %0d, %0d cycles", peak_length, LIST_CAP, cycle_count);
    if (error_count == 0) begin
      $display("positional_list_insert_delete verification clean");
    end else begin
      $display("positional_list_insert_delete verification failed");
    end
    $finish;
  end

endmodule
